// ===== design/cross_gradient_edge_detector_unit_assert.svh =====
// Assertion macros shared by the edge detector modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CROSS_GRADIENT_EDGE_DETECTOR_UNIT_ASSERT_SVH
`define CROSS_GRADIENT_EDGE_DETECTOR_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CGED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define CGED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/cged_pkg.sv =====
// Package for the cross gradient edge detector: payload types, constants,
// register codes and the per-neighbor gradient function. No dependencies.
`default_nettype none

package cged_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int MIN_SIZE      = 3;
  localparam int ROW_W         = $clog2(MAX_HEIGHT);

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [7:0]  LOW_RST    = 8'd20;
  localparam logic [7:0]  HIGH_RST   = 8'd120;
  localparam logic [7:0]  SAT_MAX    = 8'd255;

  // Division by three as a multiply by 683 and a shift by 11; exact below 2048.
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_LOW_THR      = 2'd2,
    REG_HIGH_THR     = 2'd3
  } reg_idx_t;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [7:0]         edge_value;
    logic signed [11:0] x_offset;
    logic signed [11:0] y_offset;
    logic               is_hit;
    logic               last_of_frame;
  } out_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [7:0]  low_threshold;
    logic [7:0]  high_threshold;
  } cfg_t;

  // One interior pixel's neighborhood on its way from the front to the back.
  typedef struct packed {
    pix_t        centre;
    pix_t        up;
    pix_t        down;
    pix_t        left;
    pix_t        right;
    logic [11:0] x_off;
    logic [11:0] y_off;
    logic        last;
  } rec_t;

  function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] neighbor_q(input pix_t p, input pix_t q);
    logic [9:0]  s;
    logic [20:0] prod;
    s = 10'(abs_diff8(p[23:16], q[23:16])) + 10'(abs_diff8(p[15:8], q[15:8]))
      + 10'(abs_diff8(p[7:0], q[7:0]));
    prod = 21'(s) * 21'(DIV3_MUL);
    return prod[DIV3_SH+7:DIV3_SH];
  endfunction

endpackage

`default_nettype wire

// ===== design/cross_gradient_edge_detector_unit.sv =====
// Top level of the cross gradient edge detector: register port, front end,
// queue and back end. Uses cged_pkg, cged_front, cged_fifo and cged_back.
//
//   Port group | Direction | Handshake              | Carries
//   in_        | request   | in_valid / in_ready    | cged_pkg::in_t pixel, raster order
//   out_       | result    | out_valid / out_ready  | cged_pkg::out_t, one per interior pixel
//   cfg_       | register   | psel/penable, pready=1 | four registers at byte offsets 0,4,8,12
//
// Sustained rate is one pixel per clock while in_ready is high, set by one line-store read
// and one write per cycle. A result passes the read stage, queue, gradient and output
// registers after the pixel that completes its window is accepted. Border pixels produce
// no result. Reset is synchronous and clears the counters, window, queue and output; the
// line store is not cleared and needs no clearing pass. A stalled output lets the four-entry
// queue fill; in_ready drops once the queue and the read stage together hold four records.
`default_nettype none

module cross_gradient_edge_detector_unit #(
  parameter int MAX_WIDTH = cged_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cged_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cged_pkg::out_t  out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [3:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  cged_pkg::cfg_t     cfg_r;
  cged_pkg::reg_idx_t reg_idx;
  logic               reg_wr;

  logic                         q_push, q_pop, q_not_empty;
  cged_pkg::rec_t               q_rec, q_head;
  logic [cged_pkg::QCNT_W-1:0]  q_level;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cged_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign reg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= cged_pkg::WIDTH_RST;
      cfg_r.image_height   <= cged_pkg::HEIGHT_RST;
      cfg_r.low_threshold  <= cged_pkg::LOW_RST;
      cfg_r.high_threshold <= cged_pkg::HIGH_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        cged_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width    <= cfg_pwdata[11:0];
        cged_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height   <= cfg_pwdata[11:0];
        cged_pkg::REG_LOW_THR:      cfg_r.low_threshold  <= cfg_pwdata[7:0];
        cged_pkg::REG_HIGH_THR:     cfg_r.high_threshold <= cfg_pwdata[7:0];
        default:                    cfg_r.image_width    <= cfg_r.image_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cged_pkg::REG_IMAGE_WIDTH:  cfg_prdata = {20'd0, cfg_r.image_width};
      cged_pkg::REG_IMAGE_HEIGHT: cfg_prdata = {20'd0, cfg_r.image_height};
      cged_pkg::REG_LOW_THR:      cfg_prdata = {24'd0, cfg_r.low_threshold};
      cged_pkg::REG_HIGH_THR:     cfg_prdata = {24'd0, cfg_r.high_threshold};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  cged_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_rec    (q_rec)
  );

  cged_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_rec),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .level     (q_level)
  );

  cged_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/cged_front.sv =====
// Front end: accepts pixels, keeps the raster counters, the line store and
// the cross window, and pushes interior neighborhoods. Uses cged_pkg.
`default_nettype none
`include "cross_gradient_edge_detector_unit_assert.svh"

module cged_front #(
  parameter int MAX_WIDTH = cged_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cged_pkg::in_t                in_data,
  input  cged_pkg::cfg_t               cfg,
  input  logic [cged_pkg::QCNT_W-1:0]  q_level,
  output logic                         q_push,
  output cged_pkg::rec_t               q_rec
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam int RW = cged_pkg::ROW_W;

  logic [11:0]   w_eff, h_eff;
  logic [CW-1:0] w_ext;
  logic          acc;

  logic [AW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [11:0]   row_tmp, row_p1;
  logic [CW-1:0] col_p1;

  logic          emit, last;
  logic [11:0]   x_off, y_off;
  logic [cged_pkg::QCNT_W:0] level_sum;

  logic          s1_v_r, s1_emit_r, s1_last_r;
  logic [AW-1:0] s1_col_r;
  cged_pkg::pix_t s1_pix_r;
  logic [11:0]   s1_xo_r, s1_yo_r;

  // Each entry holds the line above in the upper half and the middle line below.
  logic [47:0]   lines_mem [MAX_WIDTH];
  logic [47:0]   rd_r;
  cged_pkg::pix_t above, mid;

  cged_pkg::pix_t win_up_r, win_c_r, win_rt_r, win_dn_r;

  // Effective frame size.
  always_comb begin
    if (cfg.image_width < 12'(cged_pkg::MIN_SIZE)) begin
      w_eff = 12'(cged_pkg::MIN_SIZE);
    end else if (CW'(cfg.image_width) > CW'(MAX_WIDTH)) begin
      w_eff = 12'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    if (cfg.image_height < 12'(cged_pkg::MIN_SIZE)) begin
      h_eff = 12'(cged_pkg::MIN_SIZE);
    end else if (cfg.image_height > 12'(cged_pkg::MAX_HEIGHT)) begin
      h_eff = 12'(cged_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg.image_height;
    end
    w_ext = CW'(w_eff);
  end

  // The counters are checked again on entry so that a smaller size takes effect.
  always_comb begin
    if (CW'(col_r) >= w_ext) begin
      col_cur = '0;
      row_tmp = 12'(row_r) + 12'd1;
    end else begin
      col_cur = col_r;
      row_tmp = 12'(row_r);
    end
    row_cur = (row_tmp >= h_eff) ? '0 : row_tmp[RW-1:0];

    col_p1 = CW'(col_cur) + CW'(1);
    row_p1 = 12'(row_cur) + 12'd1;
    if (col_p1 >= w_ext) begin
      col_nxt = '0;
      row_nxt = (row_p1 >= h_eff) ? '0 : row_p1[RW-1:0];
    end else begin
      col_nxt = col_p1[AW-1:0];
      row_nxt = row_cur;
    end

    emit  = (row_cur >= RW'(2)) && (CW'(col_cur) >= CW'(2));
    last  = (12'(row_cur) == h_eff - 12'd1) && (CW'(col_cur) == w_ext - CW'(1));
    x_off = 12'(col_cur) - 12'd1 - {1'b0, w_eff[11:1]};
    y_off = {1'b0, h_eff[11:1]} - (12'(row_cur) - 12'd1);
  end

  // One queue slot is held back for the pixel in the read stage.
  assign level_sum = {1'b0, q_level} + (cged_pkg::QCNT_W + 1)'(s1_v_r);
  assign in_ready  = level_sum < (cged_pkg::QCNT_W + 1)'(cged_pkg::QDEPTH);
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r  <= col_cur;
      s1_pix_r  <= in_data;
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_xo_r   <= x_off;
      s1_yo_r   <= y_off;
    end
  end

  // Line store: read on accept, written back in the following cycle at the same column.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= lines_mem[col_cur];
    end
    if (s1_v_r) begin
      lines_mem[s1_col_r] <= {rd_r[23:0], s1_pix_r};
    end
  end

  assign above = rd_r[47:24];
  assign mid   = rd_r[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_up_r <= '0;
      win_c_r  <= '0;
      win_rt_r <= '0;
      win_dn_r <= '0;
    end else if (s1_v_r) begin
      win_up_r <= above;
      win_c_r  <= win_rt_r;
      win_rt_r <= mid;
      win_dn_r <= s1_pix_r;
    end
  end

  // The centre sits one column behind the newest middle-line entry.
  always_comb begin
    q_push       = s1_v_r && s1_emit_r;
    q_rec.centre = win_rt_r;
    q_rec.up     = win_up_r;
    q_rec.down   = win_dn_r;
    q_rec.left   = win_c_r;
    q_rec.right  = mid;
    q_rec.x_off  = s1_xo_r;
    q_rec.y_off  = s1_yo_r;
    q_rec.last   = s1_last_r;
  end

  `CGED_ASSERT_IMP(a_last_is_interior, s1_v_r && s1_last_r, s1_emit_r, "last pixel of frame not interior")

endmodule

`default_nettype wire

// ===== design/cged_fifo.sv =====
// Short queue between the front end and the gradient back end.
// Holds cged_pkg::rec_t entries; uses cged_pkg.
`default_nettype none
`include "cross_gradient_edge_detector_unit_assert.svh"

module cged_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cged_pkg::rec_t               push_rec,
  input  logic                         pop,
  output logic                         not_empty,
  output cged_pkg::rec_t               head,
  output logic [cged_pkg::QCNT_W-1:0]  level
);

  cged_pkg::rec_t                  entries [cged_pkg::QDEPTH];
  logic [cged_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cged_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + cged_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - cged_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + cged_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cged_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_rec;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = entries[rd_ptr_r];
  assign level     = cnt_r;

  `CGED_ASSERT_IMP(a_no_overflow, push && !pop, cnt_r != cged_pkg::QCNT_W'(cged_pkg::QDEPTH), "queue overflow")
  `CGED_ASSERT_IMP(a_no_underflow, pop, cnt_r != '0, "queue underflow")

endmodule

`default_nettype wire

// ===== design/cged_back.sv =====
// Back end: four neighbor gradients, sum with saturation, thresholds and
// the output register. Uses cged_pkg.
`default_nettype none
`include "cross_gradient_edge_detector_unit_assert.svh"

module cged_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  cged_pkg::rec_t  q_head,
  output logic            q_pop,
  input  cged_pkg::cfg_t  cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output cged_pkg::out_t  out_data
);

  logic [7:0]     b1_q_r [4];
  logic [11:0]    b1_xo_r, b1_yo_r;
  logic           b1_last_r, b1_v_r;
  logic           b1_ready, out_ld;

  logic [9:0]     sum;
  logic [7:0]     v_sat, v_thr;
  logic           hit;
  cged_pkg::out_t res;
  cged_pkg::out_t out_r;
  logic           out_v_r;

  assign out_ld   = b1_v_r && (!out_v_r || out_ready);
  assign b1_ready = !b1_v_r || out_ld;
  assign q_pop    = q_valid && b1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_v_r <= q_valid;
      end
      if (out_ld) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_q_r[0] <= cged_pkg::neighbor_q(q_head.centre, q_head.up);
      b1_q_r[1] <= cged_pkg::neighbor_q(q_head.centre, q_head.down);
      b1_q_r[2] <= cged_pkg::neighbor_q(q_head.centre, q_head.left);
      b1_q_r[3] <= cged_pkg::neighbor_q(q_head.centre, q_head.right);
      b1_xo_r   <= q_head.x_off;
      b1_yo_r   <= q_head.y_off;
      b1_last_r <= q_head.last;
    end
    if (out_ld) begin
      out_r <= res;
    end
  end

  always_comb begin
    sum   = 10'(b1_q_r[0]) + 10'(b1_q_r[1]) + 10'(b1_q_r[2]) + 10'(b1_q_r[3]);
    v_sat = (sum > 10'(cged_pkg::SAT_MAX)) ? cged_pkg::SAT_MAX : sum[7:0];
    hit   = (v_sat >= cfg.low_threshold);
    v_thr = hit ? v_sat : 8'd0;
    res.edge_value    = (v_thr > cfg.high_threshold) ? cged_pkg::SAT_MAX : v_thr;
    res.x_offset      = hit ? b1_xo_r : 12'sd0;
    res.y_offset      = hit ? b1_yo_r : 12'sd0;
    res.is_hit        = hit;
    res.last_of_frame = b1_last_r;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `CGED_ASSERT_IMP(a_miss_is_blank, out_v_r && !out_r.is_hit, (out_r.edge_value == 8'd0) && (out_r.x_offset == 12'sd0) && (out_r.y_offset == 12'sd0), "non-hit result carries data")

endmodule

`default_nettype wire
